// File: rtl/mh2_pkg.sv
// Shared types and constants for the MurmurHash2 engine.
package mh2_pkg;

   localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
   localparam int          MIX_SHIFT = 24;
   localparam int          AVA_SHIFT_A = 13;
   localparam int          AVA_SHIFT_B = 15;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // byte address of the seed register
   localparam logic [CSR_ADDR_W-1:0] CSR_SEED_ADDR = '0;

   // Datapath operation issued by the controller for one cycle.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_K1,     // k = k * M
      OP_K2,     // k = (k ^ k >> 24) * M
      OP_HMIX,   // h = h * M ^ k
      OP_TAIL,   // h = (h ^ tail) * M
      OP_AVAL    // h = avalanche, result register loaded
   } mh2_op_type;

   typedef struct packed {
      logic       load;  // take a new beat into h/k
      mh2_op_type op;
   } mh2_cmd_type;

endpackage

// File: rtl/mh2_csr.sv
// APB-style configuration register block holding the seed.
module mh2_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mh2_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mh2_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mh2_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [31:0]                       seed_value
);

   localparam logic REG_SEED = mh2_pkg::CSR_SEED_ADDR[2];

   logic [31:0] seed_ff;
   logic [31:0] seed_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      seed_in = seed_ff;
      if (wr_en && csr_paddr[2] == REG_SEED) begin
         seed_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_SEED) ? seed_ff : '0;
   assign seed_value = seed_ff;

endmodule

// File: rtl/mh2_dp.sv
// Hash datapath: running hash, block word and one shared constant multiplier.
module mh2_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  mh2_pkg::mh2_cmd_type cmd,
   input  logic [31:0]          data_word,
   input  logic [2:0]           byte_count,
   input  logic                 first_item,
   input  logic                 last_item,
   input  logic [31:0]          message_length,
   input  logic [31:0]          seed_value,
   output logic [31:0]          hash_value
);

   logic [31:0] h_ff, h_in;
   logic [31:0] k_ff, k_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] mul_a;
   logic [31:0] prod;
   logic [31:0] ava;
   logic [31:0] tail_mask;

   // Bytes beyond the count are dropped for a short last beat.
   always_comb begin
      case (byte_count)
         3'd1:    tail_mask = 32'h0000_00ff;
         3'd2:    tail_mask = 32'h0000_ffff;
         3'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = 32'hffff_ffff;
      endcase
   end

   always_comb begin
      case (cmd.op)
         mh2_pkg::OP_K1:   mul_a = k_ff;
         mh2_pkg::OP_K2:   mul_a = k_ff ^ (k_ff >> mh2_pkg::MIX_SHIFT);
         mh2_pkg::OP_HMIX: mul_a = h_ff;
         mh2_pkg::OP_TAIL: mul_a = h_ff ^ k_ff;
         mh2_pkg::OP_AVAL: mul_a = h_ff ^ (h_ff >> mh2_pkg::AVA_SHIFT_A);
         default:          mul_a = h_ff;
      endcase
   end

   assign prod = mul_a * mh2_pkg::MIX_MUL;
   assign ava  = prod ^ (prod >> mh2_pkg::AVA_SHIFT_B);

   always_comb begin
      h_in    = h_ff;
      k_in    = k_ff;
      hash_in = hash_ff;
      if (cmd.load) begin
         if (first_item) begin
            h_in = seed_value ^ message_length;
         end
         k_in = last_item ? (data_word & tail_mask) : data_word;
      end
      case (cmd.op)
         mh2_pkg::OP_K1:   k_in = prod;
         mh2_pkg::OP_K2:   k_in = prod;
         mh2_pkg::OP_HMIX: h_in = prod ^ k_ff;
         mh2_pkg::OP_TAIL: h_in = prod;
         mh2_pkg::OP_AVAL: begin
            h_in    = ava;
            hash_in = ava;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= '0;
      end else begin
         h_ff <= h_in;
      end
      k_ff    <= k_in;
      hash_ff <= hash_in;
   end

   assign hash_value = hash_ff;

endmodule

// File: rtl/mh2_ctrl.sv
// Sequencer for the MurmurHash2 engine: beat intake, mix steps, result handoff.
module mh2_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tlast,
   input  logic [2:0]           byte_count,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output mh2_pkg::mh2_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_K1,
      ST_K2,
      ST_HMIX,
      ST_TAIL,
      ST_AVAL
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      out_valid_ff, out_valid_in;
   logic      req_accept;
   logic      slot_free;
   logic      full_block;
   logic      empty_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign full_block = !req_tlast || (byte_count >= 3'd4);
   assign empty_last = req_tlast && (byte_count == 3'd0);

   always_comb begin
      cmd.load = req_accept;
      case (state_ff)
         ST_K1:   cmd.op = mh2_pkg::OP_K1;
         ST_K2:   cmd.op = mh2_pkg::OP_K2;
         ST_HMIX: cmd.op = mh2_pkg::OP_HMIX;
         ST_TAIL: cmd.op = mh2_pkg::OP_TAIL;
         ST_AVAL: cmd.op = slot_free ? mh2_pkg::OP_AVAL : mh2_pkg::OP_NONE;
         default: cmd.op = mh2_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               last_in = req_tlast;
               if (full_block) begin
                  state_in = ST_K1;
               end else if (empty_last) begin
                  state_in = ST_AVAL;
               end else begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_K1:   state_in = ST_K2;
         ST_K2:   state_in = ST_HMIX;
         ST_HMIX: state_in = last_ff ? ST_AVAL : ST_IDLE;
         ST_TAIL: state_in = ST_AVAL;
         ST_AVAL: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   // A taken beat always starts at least one mix step.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("ready right after an accepted beat");

   // A result only appears out of the avalanche step.
   a_result_from_aval: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_AVAL))
      else $error("result raised outside avalanche");

   // A blocked result slot holds the avalanche step back.
   a_aval_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AVAL && out_valid_ff && !rsp_tready) |=> state_ff == ST_AVAL)
      else $error("avalanche overwrote a pending result");

endmodule

// File: rtl/murmur2_hash_engine_top.sv
// Top level of the streaming 32-bit MurmurHash2 engine.
//
//  channel  dir  handshake                fields
//  req_     in   req_tvalid/req_tready    tdata: word, count, length; tuser: first; tlast
//  rsp_     out  rsp_tvalid/rsp_tready    tdata: hash
//  csr_     in   APB psel/penable/pready  seed register at byte address 0
//
// Steps per beat after the accept: K1, K2 and HMIX for a full block, TAIL for a short
// tail, none for an empty last beat; a last beat adds the avalanche step. One constant
// multiplier is shared by all steps, so the multiplies run one after another.
// Reset (synchronous, active high) clears seed and running hash to zero.
// The result sits in an output register; the next beat is taken while it waits,
// and only a second avalanche stalls until the pending hash is taken.
module murmur2_hash_engine_top (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [71:0]                    req_tdata,  // [31:0] data_word, [34:32] byte_count,
                                                      // [66:35] message_length, [71:67] zero
   input  logic                           req_tuser,  // [0] first_item
   input  logic                           req_tlast,  // last_item
   // response stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,  // [31:0] hash_value
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mh2_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mh2_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mh2_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   logic [31:0]          seed_value;
   mh2_pkg::mh2_cmd_type cmd;

   // beat fields
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic [31:0] message_length;

   assign data_word      = req_tdata[31:0];
   assign byte_count     = req_tdata[34:32];
   assign message_length = req_tdata[66:35];

   mh2_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .seed_value  (seed_value)
   );

   // sequencer: decides the step order per beat and owns the result valid
   mh2_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .byte_count (byte_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath: running hash persists across beats (non-first beats continue it)
   mh2_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .data_word      (data_word),
      .byte_count     (byte_count),
      .first_item     (req_tuser),
      .last_item      (req_tlast),
      .message_length (message_length),
      .seed_value     (seed_value),
      .hash_value     (rsp_tdata)
   );

endmodule
